// ===== sv/stm_pkg.sv =====
// Shared constants, command codes and control/status types for the sparse triplet merge.
package stm_pkg;

  localparam int DEFAULT_LIST_DEPTH = 32;
  localparam int DEFAULT_INDEX_BITS = 10;
  localparam int VALUE_BITS         = 16;
  localparam int SUM_BITS           = 17;
  localparam int CMD_BITS           = 2;

  localparam logic [CMD_BITS-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_MERGE  = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic a_more;
    logic b_more;
  } dp_stat_t;

endpackage

// ===== sv/stm_ctrl.sv =====
// Controller state machine: decodes commands and sequences the merge.
module stm_ctrl
  import stm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CMD_BITS-1:0] in_cmd,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd,
  output logic                busy
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_LOAD_A: cmd.load_a = 1'b1;
            CMD_LOAD_B: cmd.load_b = 1'b1;
            CMD_MERGE:  state_nxt = ST_MERGE;
            default:    ;
          endcase
        end
      end
      ST_MERGE: begin
        if (stat.a_more || stat.b_more) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r == ST_MERGE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/stm_dp.sv =====
// Datapath: list memories, merge pointers, head compare, pending result and output register.
module stm_dp
  import stm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic [INDEX_BITS-1:0]        in_entry_row,
  input  logic [INDEX_BITS-1:0]        in_entry_col,
  input  logic signed [VALUE_BITS-1:0] in_entry_value,
  output logic                         out_valid,
  output logic [INDEX_BITS-1:0]        out_row,
  output logic [INDEX_BITS-1:0]        out_col,
  output logic signed [SUM_BITS-1:0]   out_value,
  output logic                         out_is_last
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int KW = 2 * INDEX_BITS;
  localparam int EW = KW + VALUE_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [EW-1:0] mem_a [LIST_DEPTH];
  logic [EW-1:0] mem_b [LIST_DEPTH];

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ptr_a_r, ptr_a_nxt, ptr_b_r, ptr_b_nxt;
  logic [EW-1:0] head_a_r, head_b_r;
  logic [EW-1:0] wr_word;

  logic                       pend_vld_r, pend_vld_nxt;
  logic [KW-1:0]              pend_key_r;
  logic signed [SUM_BITS-1:0] pend_val_r;

  logic                       out_vld_r, out_vld_nxt;
  logic [KW-1:0]              out_key_r;
  logic signed [SUM_BITS-1:0] out_val_r;
  logic                       out_last_r;

  logic [KW-1:0]                key_a, key_b, res_key;
  logic signed [VALUE_BITS-1:0] val_a, val_b;
  logic signed [SUM_BITS-1:0]   ext_a, ext_b, res_val;
  logic                         take_a, take_b, res_vld, wr_a, wr_b;

  assign wr_word = {in_entry_row, in_entry_col, in_entry_value};
  assign wr_a    = cmd.load_a && (cnt_a_r < DEPTH_C);
  assign wr_b    = cmd.load_b && (cnt_b_r < DEPTH_C);

  assign stat.a_more = (ptr_a_r < cnt_a_r);
  assign stat.b_more = (ptr_b_r < cnt_b_r);

  assign key_a = head_a_r[EW-1:VALUE_BITS];
  assign key_b = head_b_r[EW-1:VALUE_BITS];
  assign val_a = $signed(head_a_r[VALUE_BITS-1:0]);
  assign val_b = $signed(head_b_r[VALUE_BITS-1:0]);
  assign ext_a = SUM_BITS'(val_a);
  assign ext_b = SUM_BITS'(val_b);

  // Pick the smaller head key; equal keys consume both heads.
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (stat.a_more && stat.b_more) begin
      take_a = (key_a <= key_b);
      take_b = (key_b <= key_a);
    end else if (stat.a_more) begin
      take_a = 1'b1;
    end else if (stat.b_more) begin
      take_b = 1'b1;
    end
  end

  always_comb begin
    if (take_a && take_b) begin
      res_val = ext_a + ext_b;
    end else if (take_a) begin
      res_val = ext_a;
    end else begin
      res_val = ext_b;
    end
  end

  assign res_key = take_a ? key_a : key_b;
  assign res_vld = cmd.step && (take_a || take_b) &&
                   !(take_a && take_b && (res_val == '0));

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    ptr_a_nxt = ptr_a_r;
    ptr_b_nxt = ptr_b_r;
    if (cmd.finish) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
      ptr_a_nxt = '0;
      ptr_b_nxt = '0;
    end else begin
      if (wr_a) cnt_a_nxt = cnt_a_r + CW'(1);
      if (wr_b) cnt_b_nxt = cnt_b_r + CW'(1);
      if (cmd.step && take_a) ptr_a_nxt = ptr_a_r + CW'(1);
      if (cmd.step && take_b) ptr_b_nxt = ptr_b_r + CW'(1);
    end
  end

  // A result is released only once the next one exists or the merge closes, so the last flag is known.
  assign pend_vld_nxt = cmd.finish ? 1'b0 : (res_vld ? 1'b1 : pend_vld_r);
  assign out_vld_nxt  = pend_vld_r && (res_vld || cmd.finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      ptr_a_r    <= '0;
      ptr_b_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      ptr_a_r    <= ptr_a_nxt;
      ptr_b_r    <= ptr_b_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_a[cnt_a_r[AW-1:0]] <= wr_word;
    if (wr_b) mem_b[cnt_b_r[AW-1:0]] <= wr_word;
    if (ptr_a_nxt < DEPTH_C) head_a_r <= mem_a[ptr_a_nxt[AW-1:0]];
    if (ptr_b_nxt < DEPTH_C) head_b_r <= mem_b[ptr_b_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      pend_key_r <= res_key;
      pend_val_r <= res_val;
    end
    if (out_vld_nxt) begin
      out_key_r  <= pend_key_r;
      out_val_r  <= pend_val_r;
      out_last_r <= cmd.finish;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_row     = out_key_r[KW-1:INDEX_BITS];
  assign out_col     = out_key_r[INDEX_BITS-1:0];
  assign out_value   = out_val_r;
  assign out_is_last = out_last_r;

endmodule

// ===== sv/sparse_triplet_merge_add_top.sv =====
// Top level of the sparse triplet merge-add block: controller plus datapath.
//
//  channel   ports                                         handshake
//  -------   --------------------------------------------  ------------------------
//  input     in_cmd, in_entry_row/col/value                word taken: start & !busy
//  result    out_row, out_col, out_value, out_is_last      word on out_valid, 1 cycle
//
// Loads never raise busy. A merge raises busy while it makes its head compares
// (a coordinate match counts once, cancelled or not) and while it closes.
// Each result waits in the pending register until the next result or the close fixes
// its last flag, then moves to the output register; the last follows busy.
// Reset empties both lists; list memory contents are not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module sparse_triplet_merge_add_top
  import stm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [CMD_BITS-1:0]          in_cmd,
  input  logic [INDEX_BITS-1:0]        in_entry_row,
  input  logic [INDEX_BITS-1:0]        in_entry_col,
  input  logic signed [VALUE_BITS-1:0] in_entry_value,
  output logic                         out_valid,
  output logic [INDEX_BITS-1:0]        out_row,
  output logic [INDEX_BITS-1:0]        out_col,
  output logic signed [SUM_BITS-1:0]   out_value,
  output logic                         out_is_last
);

  // Command and status between controller and datapath.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Decode commands and step the merge while either list has entries left.
  stm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (dp_stat),
    .cmd    (dp_cmd),
    .busy   (busy)
  );

  // Hold the lists, compare heads, and drive the result word.
  stm_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_entry_row   (in_entry_row),
    .in_entry_col   (in_entry_col),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_is_last    (out_is_last)
  );

endmodule

// ===== verif/sparse_triplet_merge_add_checker.sv =====
// Watches the sparse triplet merge ports, predicts every merged word and compares it.
module sparse_triplet_merge_add_checker
  import stm_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [CMD_BITS-1:0]          in_cmd,
  input  logic [INDEX_BITS-1:0]        in_entry_row,
  input  logic [INDEX_BITS-1:0]        in_entry_col,
  input  logic signed [VALUE_BITS-1:0] in_entry_value,
  input  logic                         out_valid,
  input  logic [INDEX_BITS-1:0]        out_row,
  input  logic [INDEX_BITS-1:0]        out_col,
  input  logic signed [SUM_BITS-1:0]   out_value,
  input  logic                         out_is_last,
  output int                           mismatch_count,
  output int                           words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_BITS-1:0]      row;
    logic [INDEX_BITS-1:0]      col;
    logic signed [SUM_BITS-1:0] value;
    logic                       last;
  } merged_word_t;

  logic [INDEX_BITS-1:0]        a_row [LIST_DEPTH];
  logic [INDEX_BITS-1:0]        a_col [LIST_DEPTH];
  logic signed [VALUE_BITS-1:0] a_val [LIST_DEPTH];
  logic [INDEX_BITS-1:0]        b_row [LIST_DEPTH];
  logic [INDEX_BITS-1:0]        b_col [LIST_DEPTH];
  logic signed [VALUE_BITS-1:0] b_val [LIST_DEPTH];
  int                           a_count;
  int                           b_count;
  merged_word_t                 expected_sums[$];
  int                           errors;

  assign mismatch_count = errors;

  task automatic report_mismatch(string what);
    if (errors < 40) $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Walk both heads in coordinate order; equal coordinates fold into one sum.
  function automatic void merge_lists();
    int                          ia;
    int                          ib;
    logic [2*INDEX_BITS-1:0]     ka;
    logic [2*INDEX_BITS-1:0]     kb;
    logic signed [SUM_BITS-1:0]  total;
    merged_word_t                w;
    merged_word_t                fresh[$];
    ia = 0;
    ib = 0;
    while (ia < a_count && ib < b_count) begin
      ka = {a_row[ia], a_col[ia]};
      kb = {b_row[ib], b_col[ib]};
      if (ka < kb) begin
        total = a_val[ia];
        fresh.push_back('{a_row[ia], a_col[ia], total, 1'b0});
        ia++;
      end else if (ka > kb) begin
        total = b_val[ib];
        fresh.push_back('{b_row[ib], b_col[ib], total, 1'b0});
        ib++;
      end else begin
        total = a_val[ia] + b_val[ib];
        if (total != 0) fresh.push_back('{a_row[ia], a_col[ia], total, 1'b0});
        ia++;
        ib++;
      end
    end
    while (ia < a_count) begin
      total = a_val[ia];
      fresh.push_back('{a_row[ia], a_col[ia], total, 1'b0});
      ia++;
    end
    while (ib < b_count) begin
      total = b_val[ib];
      fresh.push_back('{b_row[ib], b_col[ib], total, 1'b0});
      ib++;
    end
    if (fresh.size() > 0) begin
      w = fresh[fresh.size()-1];
      w.last = 1'b1;
      fresh[fresh.size()-1] = w;
    end
    foreach (fresh[i]) expected_sums.push_back(fresh[i]);
    a_count = 0;
    b_count = 0;
  endfunction

  always @(posedge clk) begin
    merged_word_t want;
    if (!rst_n) begin
      a_count = 0;
      b_count = 0;
      expected_sums.delete();
    end else begin
      // Check the result side first so a merge taken on this edge queues behind it.
      if (out_valid) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("unexpected word row=%0d col=%0d value=%0d last=%0b",
                                    out_row, out_col, out_value, out_is_last));
        end else begin
          want = expected_sums.pop_front();
          if (out_row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", out_row, want.row));
          if (out_col !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", out_col, want.col));
          if (out_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d", out_value, want.value));
          if (out_is_last !== want.last)
            report_mismatch($sformatf("is_last %0b, want %0b", out_is_last, want.last));
        end
      end
      if (start && !busy) begin
        case (in_cmd)
          CMD_LOAD_A: begin
            if (a_count < LIST_DEPTH) begin
              a_row[a_count] = in_entry_row;
              a_col[a_count] = in_entry_col;
              a_val[a_count] = in_entry_value;
              a_count++;
            end
          end
          CMD_LOAD_B: begin
            if (b_count < LIST_DEPTH) begin
              b_row[b_count] = in_entry_row;
              b_col[b_count] = in_entry_col;
              b_val[b_count] = in_entry_value;
              b_count++;
            end
          end
          CMD_MERGE: merge_lists();
          default: ;
        endcase
      end
    end
    words_pending <= expected_sums.size();
  end

endmodule

// ===== verif/sparse_triplet_merge_add_top_tb.sv =====
// Stimulus and verdict for the sparse triplet merge-add block.
module sparse_triplet_merge_add_top_tb;
  import stm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  IB          = DEFAULT_INDEX_BITS;
  localparam int                  KEY_MAX     = (1 << (2 * IB)) - 1;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED  = 2'd3;
  localparam int                  WORD_TARGET = 215;  // stop opening new sets here
  localparam int                  QUIET_AFTER = 180;  // no idling past this many words

  typedef struct packed {
    logic [IB-1:0]                row;
    logic [IB-1:0]                col;
    logic signed [VALUE_BITS-1:0] value;
  } triplet_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic [CMD_BITS-1:0]          in_cmd         = CMD_LOAD_A;
  logic [IB-1:0]                in_entry_row   = '0;
  logic [IB-1:0]                in_entry_col   = '0;
  logic signed [VALUE_BITS-1:0] in_entry_value = '0;
  logic                         busy;
  logic                         out_valid;
  logic [IB-1:0]                out_row;
  logic [IB-1:0]                out_col;
  logic signed [SUM_BITS-1:0]   out_value;
  logic                         out_is_last;
  int                           mismatch_count;
  int                           words_pending;
  int                           words_sent     = 0;

  sparse_triplet_merge_add_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_row  (in_entry_row),
    .in_entry_col  (in_entry_col),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_is_last   (out_is_last)
  );

  sparse_triplet_merge_add_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_row  (in_entry_row),
    .in_entry_col  (in_entry_col),
    .in_entry_value(in_entry_value),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_is_last   (out_is_last),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops words.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Drop start for a short random burst now and then, but keep the tail of the run dense.
  task automatic maybe_idle();
    if (words_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Present one word and hold it until the block takes it (start high, busy low).
  // Start stays high afterwards so back-to-back words need no toggle.
  task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [IB-1:0] row,
                           logic [IB-1:0] col, logic signed [VALUE_BITS-1:0] value);
    maybe_idle();
    in_cmd         <= cmd;
    in_entry_row   <= row;
    in_entry_col   <= col;
    in_entry_value <= value;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Hold the sender until every predicted merged word has come out.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // Build one pair of lists, feed them interleaved (each list in its own order), then merge.
  // Sorted sets share coordinates on purpose so sums and cancellations show up.
  task automatic load_and_merge(bit overflow, bit unsorted, bit hold_off);
    triplet_t a_words[$];
    triplet_t b_words[$];
    triplet_t t;
    triplet_t u;
    int       n_keys;
    int       key;
    int       step_max;
    int       pick;
    logic [CMD_BITS-1:0] cmd;
    key = -1;
    if (overflow) n_keys = $urandom_range(33, 36);
    else if ($urandom_range(0, 9) < 7) n_keys = $urandom_range(1, 8);
    else n_keys = $urandom_range(9, 20);
    if (unsorted) n_keys = $urandom_range(0, 6);
    for (int i = 0; i < n_keys; i++) begin
      if (unsorted) begin
        key = $urandom_range(0, KEY_MAX);
      end else begin
        step_max = (KEY_MAX - key) / (n_keys - i);
        key      = key + $urandom_range(1, step_max);
      end
      t.row   = key[2*IB-1:IB];
      t.col   = key[IB-1:0];
      t.value = VALUE_BITS'($urandom);
      u       = t;
      u.value = VALUE_BITS'($urandom);
      pick    = overflow ? 9 : $urandom_range(0, 9);
      if (pick < 4) begin
        a_words.push_back(t);
      end else if (pick < 8) begin
        b_words.push_back(u);
      end else begin
        // Same coordinate in both lists: often cancel, otherwise a plain sum.
        if ($urandom_range(0, 1) == 1) u.value = -t.value;
        a_words.push_back(t);
        b_words.push_back(u);
      end
    end
    while (a_words.size() > 0 || b_words.size() > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        t = $bits(triplet_t)'($urandom);
        send_word(CMD_UNUSED, t.row, t.col, t.value);
      end
      if (b_words.size() == 0 || (a_words.size() > 0 && $urandom_range(0, 1) == 0)) begin
        t   = a_words.pop_front();
        cmd = CMD_LOAD_A;
      end else begin
        t   = b_words.pop_front();
        cmd = CMD_LOAD_B;
      end
      send_word(cmd, t.row, t.col, t.value);
    end
    if (hold_off) drain_results();
    t = $bits(triplet_t)'($urandom);
    send_word(CMD_MERGE, t.row, t.col, t.value);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Merge with both lists empty: no word.
    send_word(CMD_MERGE, '0, '0, '0);
    // Extremes: most negative sum, most positive sum, row compared before column,
    // and a pair that cancels inside a larger merge.
    send_word(CMD_LOAD_A, 10'd0, 10'd0, -16'sd32768);
    send_word(CMD_LOAD_B, 10'd0, 10'd0, -16'sd32768);
    send_word(CMD_LOAD_A, 10'd1, 10'd1023, 16'sd1);
    send_word(CMD_LOAD_B, 10'd2, 10'd0, 16'sd2);
    send_word(CMD_LOAD_A, 10'd5, 10'd7, 16'sd100);
    send_word(CMD_LOAD_B, 10'd5, 10'd7, -16'sd100);
    send_word(CMD_LOAD_A, 10'd1023, 10'd1023, 16'sd32767);
    send_word(CMD_LOAD_B, 10'd1023, 10'd1023, 16'sd32767);
    send_word(CMD_MERGE, 10'd1023, 10'd1023, 16'hFFFF);
    // Unused command is ignored.
    send_word(CMD_UNUSED, 10'd1023, 10'd1023, -16'sd1);
    // Every entry cancels: merge gives nothing but still empties the lists.
    send_word(CMD_LOAD_A, 10'd5, 10'd7, -16'sd1);
    send_word(CMD_LOAD_B, 10'd5, 10'd7, 16'sd1);
    send_word(CMD_MERGE, '0, '0, '0);
    // Unsorted lists go through the same head compares.
    send_word(CMD_LOAD_A, 10'd9, 10'd9, 16'sd1);
    send_word(CMD_LOAD_A, 10'd3, 10'd3, 16'sd2);
    send_word(CMD_LOAD_B, 10'd5, 10'd5, 16'sd3);
    send_word(CMD_LOAD_B, 10'd0, 10'd1, -16'sd5);
    send_word(CMD_MERGE, '0, '0, '0);
    // Only list B filled.
    send_word(CMD_LOAD_B, 10'd4, 10'd4, 16'sd7);
    send_word(CMD_MERGE, '0, '0, '0);
    // A zero entry in one list only passes through unchanged.
    send_word(CMD_LOAD_A, 10'd700, 10'd300, 16'sd0);
    send_word(CMD_MERGE, '0, '0, '0);

    // First random set overfills both lists and waits for the pipe to empty first.
    load_and_merge(1'b1, 1'b0, 1'b1);
    while (words_sent < WORD_TARGET) begin
      pick_set: begin
        int roll;
        roll = $urandom_range(0, 19);
        load_and_merge(roll == 0, roll == 1 || roll == 2, $urandom_range(0, 6) == 0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/stm_pkg.sv
sv/stm_ctrl.sv
sv/stm_dp.sv
sv/sparse_triplet_merge_add_top.sv
verif/sparse_triplet_merge_add_checker.sv
verif/sparse_triplet_merge_add_top_tb.sv
